@@ design/psd_pkg.sv @@
// shared types and widths for the point-to-segment distance pipeline
// no dependencies; imported by every design file
package psd_pkg;

  localparam int COORD_W = 24;               // signed Q12.12 coordinate
  localparam int T_FRAC  = 16;               // fraction bits of the projection parameter
  localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
  localparam int L2_W    = 2 * COORD_W + 1;  // squared segment length
  localparam int DOT_W   = L2_W + 1;         // signed dot product
  localparam int REM_W   = L2_W + 1;         // divider partial remainder
  localparam int T_W     = T_FRAC + 1;       // t, including the value one
  localparam int LERP_W  = T_W + COORD_W;    // t times a difference magnitude
  localparam int Q_W     = LERP_W - T_FRAC;  // projection offset magnitude
  localparam int DX_W    = COORD_W + 2;      // point minus projection
  localparam int SQ_W    = 2 * COORD_W + 3;  // squared distance
  localparam int ROOT_W  = COORD_W + 2;      // integer root of the squared distance
  localparam int DIST_W  = 25;               // saturated output distance

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } psd_out_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic                     degenerate;
    logic                     use_quot;
    logic [T_W-1:0]           t_fixed;
  } div_side_t;

endpackage

@@ design/point_segment_distance.sv @@
// distance from a query point to a line segment, fully pipelined
// depends on psd_pkg, psd_divider and psd_sqrt
//
// query channel: query_valid/query_ready with query carrying point, start
// and end as signed Q12.12. result channel: result_valid/result_ready with
// result carrying the distance (unsigned Q13.12, saturated) and a flag for
// a segment whose ends coincide, in which case the distance to start is given.
// Each query gives exactly one result, in order.
// From query transfer to result valid a query passes three stages of
// differences, products and sums, a 16-stage divider for the projection
// parameter, four stages for the projection and squared distance, a 26-stage
// square root and the output register. One query is taken every cycle while
// not stalled. The pipeline advances as one: while a result waits in the
// output register and result_ready is low, every stage holds and query_ready
// is low. Reset is synchronous and clears only the valid bits; no results
// are pending after it.
module point_segment_distance import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     query_valid,
  output logic     query_ready,
  input  psd_in_t  query,
  output logic     result_valid,
  input  logic     result_ready,
  output psd_out_t result
);

  logic en;
  assign en          = !result_valid || result_ready;
  assign query_ready = en;

  // stage 1: differences
  logic                     s1_valid;
  logic signed [DIFF_W-1:0] s1_ux, s1_uy, s1_vx, s1_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ux <= DIFF_W'(query.end_x) - DIFF_W'(query.start_x);
      s1_uy <= DIFF_W'(query.end_y) - DIFF_W'(query.start_y);
      s1_vx <= DIFF_W'(query.point_x) - DIFF_W'(query.start_x);
      s1_vy <= DIFF_W'(query.point_y) - DIFF_W'(query.start_y);
    end
  end

  // stage 2: products
  logic                       s2_valid;
  logic signed [2*DIFF_W-1:0] s2_uux, s2_uuy, s2_vux, s2_vuy;
  logic signed [DIFF_W-1:0]   s2_ux, s2_uy, s2_vx, s2_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_uux <= s1_ux * s1_ux;
      s2_uuy <= s1_uy * s1_uy;
      s2_vux <= s1_vx * s1_ux;
      s2_vuy <= s1_vy * s1_uy;
      s2_ux  <= s1_ux;
      s2_uy  <= s1_uy;
      s2_vx  <= s1_vx;
      s2_vy  <= s1_vy;
    end
  end

  // stage 3: squared length and dot product
  logic                     s3_valid;
  logic [L2_W-1:0]          s3_l2;
  logic signed [DOT_W-1:0]  s3_dot;
  logic signed [DIFF_W-1:0] s3_ux, s3_uy, s3_vx, s3_vy;
  logic signed [2*DIFF_W:0] l2_sum, dot_sum;

  always_comb begin
    l2_sum  = (2*DIFF_W+1)'(s2_uux) + (2*DIFF_W+1)'(s2_uuy);
    dot_sum = (2*DIFF_W+1)'(s2_vux) + (2*DIFF_W+1)'(s2_vuy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_l2  <= l2_sum[L2_W-1:0];
      s3_dot <= dot_sum[DOT_W-1:0];
      s3_ux  <= s2_ux;
      s3_uy  <= s2_uy;
      s3_vx  <= s2_vx;
      s3_vy  <= s2_vy;
    end
  end

  // clamp decision in front of the divider
  div_side_t        dv_side_in, dv_side;
  logic [REM_W-1:0] dv_rem;
  logic             dv_valid;
  logic [T_FRAC-1:0] dv_quot;

  always_comb begin
    dv_side_in.ux         = s3_ux;
    dv_side_in.uy         = s3_uy;
    dv_side_in.vx         = s3_vx;
    dv_side_in.vy         = s3_vy;
    dv_side_in.degenerate = s3_l2 == '0;
    dv_side_in.use_quot   = 1'b0;
    dv_side_in.t_fixed    = '0;
    dv_rem                = '0;
    if (s3_l2 != '0 && s3_dot > 0) begin
      if (REM_W'(s3_dot) >= {1'b0, s3_l2}) begin
        dv_side_in.t_fixed = T_W'(1) << T_FRAC;
      end else begin
        dv_side_in.use_quot = 1'b1;
        dv_rem              = REM_W'(s3_dot);
      end
    end
  end

  psd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .in_rem   (dv_rem),
    .in_l2    (s3_l2),
    .in_side  (dv_side_in),
    .out_valid(dv_valid),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // stage 5: t times the segment direction magnitudes
  logic [T_W-1:0]           t_val;
  logic [COORD_W-1:0]       umag_x, umag_y;
  logic                     s5_valid, s5_negx, s5_negy, s5_degen;
  logic [LERP_W-1:0]        s5_px, s5_py;
  logic signed [DIFF_W-1:0] s5_vx, s5_vy;

  always_comb begin
    t_val  = dv_side.use_quot ? {1'b0, dv_quot} : dv_side.t_fixed;
    umag_x = dv_side.ux[DIFF_W-1] ? COORD_W'(-dv_side.ux) : COORD_W'(dv_side.ux);
    umag_y = dv_side.uy[DIFF_W-1] ? COORD_W'(-dv_side.uy) : COORD_W'(dv_side.uy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_px    <= LERP_W'(t_val) * LERP_W'(umag_x);
      s5_py    <= LERP_W'(t_val) * LERP_W'(umag_y);
      s5_negx  <= dv_side.ux[DIFF_W-1];
      s5_negy  <= dv_side.uy[DIFF_W-1];
      s5_vx    <= dv_side.vx;
      s5_vy    <= dv_side.vy;
      s5_degen <= dv_side.degenerate;
    end
  end

  // stage 6: offset from the point to its projection, floor toward minus infinity
  localparam logic [LERP_W-1:0] ROUND_UP = LERP_W'((1 << T_FRAC) - 1);

  logic [LERP_W-1:0]      px_adj, py_adj;
  logic [Q_W-1:0]         qx, qy;
  logic signed [DX_W-1:0] qx_s, qy_s;
  logic                   s6_valid, s6_degen;
  logic signed [DX_W-1:0] s6_dx, s6_dy;

  always_comb begin
    px_adj = s5_negx ? s5_px + ROUND_UP : s5_px;
    py_adj = s5_negy ? s5_py + ROUND_UP : s5_py;
    qx     = px_adj[LERP_W-1:T_FRAC];
    qy     = py_adj[LERP_W-1:T_FRAC];
    qx_s   = $signed({1'b0, qx});
    qy_s   = $signed({1'b0, qy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_dx    <= s5_negx ? DX_W'(s5_vx) + qx_s : DX_W'(s5_vx) - qx_s;
      s6_dy    <= s5_negy ? DX_W'(s5_vy) + qy_s : DX_W'(s5_vy) - qy_s;
      s6_degen <= s5_degen;
    end
  end

  // stage 7: squares
  logic                     s7_valid, s7_degen;
  logic signed [2*DX_W-1:0] s7_sqx, s7_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sqx   <= s6_dx * s6_dx;
      s7_sqy   <= s6_dy * s6_dy;
      s7_degen <= s6_degen;
    end
  end

  // stage 8: squared distance
  logic            s8_valid, s8_degen;
  logic [SQ_W-1:0] s8_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_sq    <= SQ_W'(s7_sqx[SQ_W-2:0]) + SQ_W'(s7_sqy[SQ_W-2:0]);
      s8_degen <= s7_degen;
    end
  end

  logic              rt_valid, rt_degen;
  logic [ROOT_W-1:0] rt_root;

  psd_sqrt u_sqrt (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s8_valid),
    .in_sq         (s8_sq),
    .in_degenerate (s8_degen),
    .out_valid     (rt_valid),
    .out_root      (rt_root),
    .out_degenerate(rt_degen)
  );

  // output register with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.distance   <= (rt_root[ROOT_W-1:DIST_W] != '0) ? '1 : rt_root[DIST_W-1:0];
      result.degenerate <= rt_degen;
    end
  end

endmodule

@@ design/psd_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on psd_pkg
module psd_divider import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [REM_W-1:0] in_rem,
  input  logic [L2_W-1:0]  in_l2,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [T_FRAC-1:0] out_quot,
  output div_side_t        out_side
);

  logic              vld  [T_FRAC+1];
  logic [REM_W-1:0]  rem  [T_FRAC+1];
  logic [L2_W-1:0]   l2s  [T_FRAC+1];
  logic [T_FRAC-1:0] quot [T_FRAC+1];
  div_side_t         side [T_FRAC+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign l2s[0]  = in_l2;
  assign quot[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < T_FRAC; k++) begin : g_stage
    logic [REM_W-1:0] shifted;
    logic             take;

    always_comb begin
      shifted = {rem[k][REM_W-2:0], 1'b0};
      take    = shifted >= {1'b0, l2s[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? shifted - {1'b0, l2s[k]} : shifted;
        l2s[k+1]  <= l2s[k];
        quot[k+1] <= {quot[k][T_FRAC-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[T_FRAC];
  assign out_quot  = quot[T_FRAC];
  assign out_side  = side[T_FRAC];

endmodule

@@ design/psd_sqrt.sv @@
// pipelined integer square root, one root bit per stage, msb first
// depends on psd_pkg
module psd_sqrt import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  input  logic              in_degenerate,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic              out_degenerate
);

  localparam int TR_W = SQ_W + 2;

  logic              vld   [ROOT_W+1];
  logic [SQ_W-1:0]   rest  [ROOT_W+1];
  logic [ROOT_W-1:0] root  [ROOT_W+1];
  logic              degen [ROOT_W+1];

  assign vld[0]   = in_valid;
  assign rest[0]  = in_sq;
  assign root[0]  = '0;
  assign degen[0] = in_degenerate;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [TR_W-1:0] trial;
    logic            take;

    // (2r + 2^b) * 2^b is what setting bit b adds to the square
    always_comb begin
      trial = (TR_W'(root[k]) << (B + 1)) + (TR_W'(1) << (2 * B));
      take  = TR_W'(rest[k]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rest[k+1]  <= take ? SQ_W'(TR_W'(rest[k]) - trial) : rest[k];
        root[k+1]  <= take ? (root[k] | (ROOT_W'(1) << B)) : root[k];
        degen[k+1] <= degen[k];
      end
    end
  end

  assign out_valid      = vld[ROOT_W];
  assign out_root       = root[ROOT_W];
  assign out_degenerate = degen[ROOT_W];

endmodule
